[rtl/core/pihit_pkg.sv]
// ----------------------------------------------------------------------------
// pihit_pkg
// shared types and constants for the point-in-quad hit test core
// ----------------------------------------------------------------------------
package pihit_pkg;

  localparam int CFG_IDX_BITS = 4;

  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER0_X = 4'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER0_Y = 4'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER1_X = 4'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER1_Y = 4'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER2_X = 4'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER2_Y = 4'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER3_X = 4'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_CORNER3_Y = 4'd7;

  // stage load enables, front to back
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pipe_en_t;

  // per-edge result at the end of the edge pipeline
  typedef struct packed {
    logic neg;
    logic zero;
    logic on_box;
  } edge_flags_t;

endpackage

[rtl/core/point_in_quad_hit_test_core.sv]
// ----------------------------------------------------------------------------
// point_in_quad_hit_test_core
// reports whether a point lies inside or on a configured quadrilateral
// ----------------------------------------------------------------------------
//  channel | direction | handshake       | payload
//  in      | input     | in_valid/stall  | in_point_x, in_point_y
//  out     | output    | out_valid/stall | out_inside_res
//  cfg     | input     | cfg_we          | cfg_idx, cfg_data
//
//  one point per cycle while the output is not stalled; registered steps are
//  differences, products, subtract and sign, output register
//  the pipeline stages are set by the edge multipliers and the wide subtract
//  stages close up bubbles, so a stalled output only stops the input once full
//  reset clears valid bits and the corners to zero
// ----------------------------------------------------------------------------
module point_in_quad_hit_test_core
  import pihit_pkg::*;
#(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         out_inside_res,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_BITS-1:0]      cfg_idx,
  input  logic [COORD_BITS-1:0]        cfg_data
);

  logic signed [COORD_BITS-1:0] c0x_r, c0y_r, c1x_r, c1y_r;
  logic signed [COORD_BITS-1:0] c2x_r, c2y_r, c3x_r, c3y_r;
  logic                         v1_r, v2_r, v3_r, out_valid_r;
  logic                         en_out;
  logic                         inside_nxt, inside_r;
  pipe_en_t                     en;
  edge_flags_t                  fa, fb, fc, fd;

  // corner registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0x_r <= '0;
      c0y_r <= '0;
      c1x_r <= '0;
      c1y_r <= '0;
      c2x_r <= '0;
      c2y_r <= '0;
      c3x_r <= '0;
      c3y_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CORNER0_X: c0x_r <= cfg_data;
        REG_CORNER0_Y: c0y_r <= cfg_data;
        REG_CORNER1_X: c1x_r <= cfg_data;
        REG_CORNER1_Y: c1y_r <= cfg_data;
        REG_CORNER2_X: c2x_r <= cfg_data;
        REG_CORNER2_Y: c2y_r <= cfg_data;
        REG_CORNER3_X: c3x_r <= cfg_data;
        REG_CORNER3_Y: c3y_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage enables, a stage loads when empty or when it drains
  always_comb begin
    en_out   = !out_valid_r || !out_stall;
    en.s3    = !v3_r || en_out;
    en.s2    = !v2_r || en.s3;
    en.s1    = !v1_r || en.s2;
    in_stall = !en.s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en.s1) v1_r <= in_valid;
      if (en.s2) v2_r <= v1_r;
      if (en.s3) v3_r <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  // edge a: c0->c1, b: c2->c3, c: c1->c2, d: c3->c0
  pihit_edge #(.COORD_BITS(COORD_BITS)) u_edge_a (
    .clk(clk), .en(en), .sx(c0x_r), .sy(c0y_r), .ex(c1x_r), .ey(c1y_r),
    .px(in_point_x), .py(in_point_y), .flags(fa)
  );

  pihit_edge #(.COORD_BITS(COORD_BITS)) u_edge_b (
    .clk(clk), .en(en), .sx(c2x_r), .sy(c2y_r), .ex(c3x_r), .ey(c3y_r),
    .px(in_point_x), .py(in_point_y), .flags(fb)
  );

  pihit_edge #(.COORD_BITS(COORD_BITS)) u_edge_c (
    .clk(clk), .en(en), .sx(c1x_r), .sy(c1y_r), .ex(c2x_r), .ey(c2y_r),
    .px(in_point_x), .py(in_point_y), .flags(fc)
  );

  pihit_edge #(.COORD_BITS(COORD_BITS)) u_edge_d (
    .clk(clk), .en(en), .sx(c3x_r), .sy(c3y_r), .ex(c0x_r), .ey(c0y_r),
    .px(in_point_x), .py(in_point_y), .flags(fd)
  );

  // on an edge, or strictly on the same side of both opposite pairs
  always_comb begin
    inside_nxt = (fa.zero && fa.on_box) || (fb.zero && fb.on_box) ||
                 (fc.zero && fc.on_box) || (fd.zero && fd.on_box) ||
                 (!fa.zero && !fb.zero && (fa.neg == fb.neg) &&
                  !fc.zero && !fd.zero && (fc.neg == fd.neg));
  end

  always_ff @(posedge clk) begin
    if (en_out) inside_r <= inside_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_inside_res = inside_r;

  // a stalled input means every stage holds an item
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && v3_r && out_valid_r))
    else $error("input stalled with an empty stage");

  // an accepted transfer lands in the first stage
  a_accept_lands : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted transfer lost at stage one");

  // a result only leaves when it was taken
  a_no_drop : assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid_r) |-> !$past(out_stall))
    else $error("result dropped while stalled");

endmodule

[rtl/core/pihit_edge.sv]
// ----------------------------------------------------------------------------
// pihit_edge
// three-stage cross product sign and bounding box test for one edge
// ----------------------------------------------------------------------------
module pihit_edge
  import pihit_pkg::*;
#(
  parameter int COORD_BITS = 20
) (
  input  logic                         clk,
  input  pipe_en_t                     en,
  input  logic signed [COORD_BITS-1:0] sx,
  input  logic signed [COORD_BITS-1:0] sy,
  input  logic signed [COORD_BITS-1:0] ex,
  input  logic signed [COORD_BITS-1:0] ey,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  output edge_flags_t                  flags
);

  localparam int D = COORD_BITS + 1;
  localparam int P = 2 * D;

  logic signed [D-1:0] ddx_nxt, ddy_nxt, dpx_nxt, dpy_nxt;
  logic signed [D-1:0] ddx_r, ddy_r, dpx_r, dpy_r;
  logic                box_nxt, box1_r, box2_r, box3_r;
  logic signed [P-1:0] pa_nxt, pb_nxt, pa_r, pb_r;
  logic signed [P:0]   diff;
  logic                neg_r, zero_r;

  // stage 1: differences and box test
  always_comb begin
    ddx_nxt = D'(ex) - D'(sx);
    ddy_nxt = D'(ey) - D'(sy);
    dpx_nxt = D'(px) - D'(sx);
    dpy_nxt = D'(py) - D'(sy);
    box_nxt = ((sx <= px && px <= ex) || (ex <= px && px <= sx)) &&
              ((sy <= py && py <= ey) || (ey <= py && py <= sy));
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      ddx_r  <= ddx_nxt;
      ddy_r  <= ddy_nxt;
      dpx_r  <= dpx_nxt;
      dpy_r  <= dpy_nxt;
      box1_r <= box_nxt;
    end
  end

  // stage 2: the two products
  always_comb begin
    pa_nxt = P'(ddx_r) * P'(dpy_r);
    pb_nxt = P'(dpx_r) * P'(ddy_r);
  end

  always_ff @(posedge clk) begin
    if (en.s2) begin
      pa_r   <= pa_nxt;
      pb_r   <= pb_nxt;
      box2_r <= box1_r;
    end
  end

  // stage 3: subtract and classify sign
  assign diff = (P+1)'(pa_r) - (P+1)'(pb_r);

  always_ff @(posedge clk) begin
    if (en.s3) begin
      neg_r  <= diff[P];
      zero_r <= (diff == '0);
      box3_r <= box2_r;
    end
  end

  assign flags.neg    = neg_r;
  assign flags.zero   = zero_r;
  assign flags.on_box = box3_r;

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for point_in_quad_hit_test_core: loads quadrilateral
// corners over the cfg port, streams query points through the valid/stall
// channel and checks every inside flag against an exact integer
// cross-product predictor, under random idling and long output hold-offs
// ----------------------------------------------------------------------------
module tb
  import pihit_pkg::*;
();

  localparam int CB = 20;
  localparam int PIPE_LAT = 4;
  localparam int HOLD_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint COORD_MIN = -(longint'(1) << (CB - 1));
  localparam longint COORD_MAX = (longint'(1) << (CB - 1)) - 1;

  typedef logic signed [CB-1:0] coord_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  coord_t in_point_x = '0;
  coord_t in_point_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic out_inside_res;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_idx = REG_CORNER0_X;
  logic [CB-1:0] cfg_data = '0;

  longint corner_m [8];
  longint quad_now [8];
  bit expected_inside_q [$];
  bit head_inside;
  int err_cnt = 0;
  int checked_cnt = 0;
  int inside_cnt = 0;
  int quad_cnt = 1;
  int cycle_cnt = 0;
  int stall_left = 0;
  bit burst_idle = 1'b0;
  bit hold_on = 1'b0;

  point_in_quad_hit_test_core #(
    .COORD_BITS(CB)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_point_x(in_point_x),
    .in_point_y(in_point_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_inside_res(out_inside_res),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  function automatic longint clamp_coord(longint v);
    return (v < COORD_MIN) ? COORD_MIN : ((v > COORD_MAX) ? COORD_MAX : v);
  endfunction

  function automatic longint rand_coord();
    return longint'(coord_t'($urandom()));
  endfunction

  function automatic int cross_sign(longint sx, longint sy, longint ex, longint ey,
                                    longint px, longint py);
    longint cr;
    cr = (ex - sx) * (py - sy) - (px - sx) * (ey - sy);
    if (cr < 0)
      return -1;
    return (cr == 0) ? 0 : 1;
  endfunction

  function automatic bit edge_hit(longint sx, longint sy, longint ex, longint ey,
                                  longint px, longint py, int sg);
    longint xlo, xhi, ylo, yhi;
    xlo = (sx < ex) ? sx : ex;
    xhi = (sx < ex) ? ex : sx;
    ylo = (sy < ey) ? sy : ey;
    yhi = (sy < ey) ? ey : sy;
    return sg == 0 && px >= xlo && px <= xhi && py >= ylo && py <= yhi;
  endfunction

  // edges run corner k -> corner k+1
  function automatic bit quad_contains(longint px, longint py);
    int sg [4];
    bit hit;
    hit = 1'b0;
    for (int k = 0; k < 4; k++) begin
      sg[k] = cross_sign(corner_m[2*k], corner_m[2*k+1], corner_m[2*((k+1)%4)],
                         corner_m[2*((k+1)%4)+1], px, py);
      if (edge_hit(corner_m[2*k], corner_m[2*k+1], corner_m[2*((k+1)%4)],
                   corner_m[2*((k+1)%4)+1], px, py, sg[k]))
        hit = 1'b1;
    end
    if (sg[0] != 0 && sg[0] == sg[2] && sg[1] != 0 && sg[1] == sg[3])
      hit = 1'b1;
    return hit;
  endfunction

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= 50)
      $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_we && cfg_idx <= REG_CORNER3_Y)
        corner_m[cfg_idx[2:0]] = longint'($signed(cfg_data));
      if (in_valid && !in_stall)
        expected_inside_q.push_back(quad_contains(in_point_x, in_point_y));
      if (out_valid && !out_stall) begin
        if (expected_inside_q.size() == 0) begin
          report_mismatch($sformatf("result with no point pending, inside_res=%b",
                                    out_inside_res));
        end else begin
          head_inside = expected_inside_q.pop_front();
          checked_cnt++;
          if (out_inside_res !== head_inside)
            report_mismatch($sformatf("inside_res got %b expected %b",
                                      out_inside_res, head_inside));
          else if (head_inside)
            inside_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (burst_idle && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_stall <= hold_on;
    end
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("run stopped at the cycle limit with %0d results pending",
             expected_inside_q.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic longint gcd_abs(longint a, longint b);
    longint t;
    if (a < 0)
      a = -a;
    if (b < 0)
      b = -b;
    while (b != 0) begin
      t = a % b;
      a = b;
      b = t;
    end
    return a;
  endfunction

  // points on edges, on edge lines past the corners, near the quad and anywhere
  function automatic void pick_point(output longint px, output longint py);
    int mode, k;
    longint sx, sy, ex, ey, g, j, xlo, xhi, ylo, yhi;
    mode = $urandom_range(0, 99);
    k = $urandom_range(0, 3);
    sx = quad_now[2*k];
    sy = quad_now[2*k+1];
    ex = quad_now[2*((k+1)%4)];
    ey = quad_now[2*((k+1)%4)+1];
    g = gcd_abs(ex - sx, ey - sy);
    if (g == 0)
      g = 1;
    xlo = quad_now[0];
    xhi = quad_now[0];
    ylo = quad_now[1];
    yhi = quad_now[1];
    for (int c = 1; c < 4; c++) begin
      if (quad_now[2*c] < xlo) xlo = quad_now[2*c];
      if (quad_now[2*c] > xhi) xhi = quad_now[2*c];
      if (quad_now[2*c+1] < ylo) ylo = quad_now[2*c+1];
      if (quad_now[2*c+1] > yhi) yhi = quad_now[2*c+1];
    end
    if (mode < 30 || mode >= 85 && mode < 90) begin
      j = (mode < 30) ? longint'($urandom_range(0, int'(g))) : 0;
      px = sx + j * ((ex - sx) / g);
      py = sy + j * ((ey - sy) / g);
      if (mode >= 85) begin
        px = px + $urandom_range(0, 2) - 1;
        py = py + $urandom_range(0, 2) - 1;
      end
    end else if (mode < 38) begin
      j = $urandom_range(0, 1) ? -1 - longint'($urandom_range(0, 3))
                               : g + 1 + longint'($urandom_range(0, 3));
      px = sx + j * ((ex - sx) / g);
      py = sy + j * ((ey - sy) / g);
    end else if (mode < 85) begin
      px = xlo - 8 + longint'($urandom_range(0, int'(xhi - xlo + 16)));
      py = ylo - 8 + longint'($urandom_range(0, int'(yhi - ylo + 16)));
    end else begin
      px = rand_coord();
      py = rand_coord();
    end
    px = clamp_coord(px);
    py = clamp_coord(py);
  endfunction

  function automatic void random_quad(output longint q [8]);
    int kind, r, dx, dy;
    longint cx, cy;
    longint a [4], b [4];
    kind = $urandom_range(0, 8);
    r = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 1 << 18) : $urandom_range(1, 64);
    cx = ($urandom_range(0, 3) == 0) ? rand_coord() : longint'($urandom_range(0, 4000)) - 2000;
    cy = ($urandom_range(0, 3) == 0) ? rand_coord() : longint'($urandom_range(0, 4000)) - 2000;
    for (int k = 0; k < 4; k++) begin
      a[k] = $urandom_range(1, r);
      b[k] = $urandom_range(1, r);
    end
    case (kind)
      0, 1: begin
        q = '{cx - a[0], cy - b[0], cx + a[1], cy - b[1],
              cx + a[2], cy + b[2], cx - a[3], cy + b[3]};
      end
      2: begin
        q = '{cx - a[0], cy - b[0], cx + a[1], cy - b[0],
              cx + a[1], cy + b[1], cx - a[0], cy + b[1]};
      end
      3: begin
        q = '{cx - a[0], cy - b[0], cx + a[1], cy - b[1],
              cx - a[3], cy + b[3], cx + a[2], cy + b[2]};
      end
      4: begin
        q = '{cx - a[0], cy - b[0], cx - a[3], cy + b[3],
              cx + a[2], cy + b[2], cx + a[1], cy - b[1]};
      end
      5: begin
        for (int k = 0; k < 8; k++)
          q[k] = ((k % 2) ? cy : cx) + longint'($urandom_range(0, 2 * r)) - r;
      end
      6: begin
        for (int k = 0; k < 8; k++)
          q[k] = rand_coord();
      end
      7: begin
        q = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
              COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX};
      end
      default: begin
        // collinear or single-point quad
        dx = $urandom_range(0, 1) ? int'($urandom_range(0, 8)) - 4 : 0;
        dy = $urandom_range(0, 1) ? int'($urandom_range(0, 8)) - 4 : 0;
        for (int k = 0; k < 4; k++) begin
          q[2*k] = cx + k * dx * 3;
          q[2*k+1] = cy + k * dy * 3;
        end
      end
    endcase
    for (int k = 0; k < 8; k++)
      q[k] = clamp_coord(q[k]);
  endfunction

  // stray writes to the unused register indexes go after the corners
  task automatic load_quad(input longint q [8], input bit with_unused);
    int last;
    last = with_unused ? (1 << CFG_IDX_BITS) - 1 : int'(REG_CORNER3_Y);
    for (int k = 0; k <= last; k++) begin
      cfg_we <= 1'b1;
      cfg_idx <= CFG_IDX_BITS'(k);
      if (k <= int'(REG_CORNER3_Y)) begin
        quad_now[k] = clamp_coord(q[k]);
        cfg_data <= coord_t'(quad_now[k]);
      end else begin
        cfg_data <= coord_t'($urandom());
      end
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    quad_cnt++;
  endtask

  task automatic send_point(input longint px, input longint py);
    int gap;
    if (burst_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= coord_t'(px);
    in_point_y <= coord_t'(py);
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_inside_q.size() != 0);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  // all corners at zero after reset: only the origin hits
  task automatic test_reset_corners();
    send_point(0, 0);
    send_point(1, 0);
    send_point(0, -1);
    send_point(COORD_MAX, COORD_MIN);
    drain_results();
  endtask

  task automatic test_square();
    longint q [8];
    q = '{-256, -256, 256, -256, 256, 256, -256, 256};
    load_quad(q, 1'b1);
    send_point(0, 0);
    send_point(-256, -256);
    send_point(256, 256);
    send_point(0, -256);
    send_point(256, 100);
    send_point(300, -256);
    send_point(257, 0);
    send_point(-257, 0);
    send_point(0, 257);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX);
    send_point(COORD_MIN, COORD_MAX);
    drain_results();
  endtask

  task automatic test_full_span();
    longint q [8];
    q = '{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
          COORD_MAX, COORD_MAX, COORD_MIN, COORD_MAX};
    load_quad(q, 1'b0);
    send_point(COORD_MIN, COORD_MIN);
    send_point(COORD_MAX, COORD_MAX);
    send_point(0, 0);
    send_point(COORD_MIN, 0);
    send_point(-1, -1);
    drain_results();
  endtask

  task automatic test_random_quads();
    longint q [8];
    longint px, py;
    burst_idle <= 1'b1;
    for (int s = 0; s < 14; s++) begin
      random_quad(q);
      load_quad(q, s % 4 == 0);
      for (int n = 0; n < 30; n++) begin
        pick_point(px, py);
        send_point(px, py);
      end
      drain_results();
    end
  endtask

  // receiver holds off long enough for the pipeline to fill and stall the input
  task automatic test_output_holdoff();
    longint q [8];
    longint px, py;
    random_quad(q);
    load_quad(q, 1'b0);
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
      begin
        for (int n = 0; n < 40; n++) begin
          pick_point(px, py);
          send_point(px, py);
        end
      end
    join
    drain_results();
  endtask

  task automatic test_streaming();
    longint q [8];
    longint px, py;
    burst_idle <= 1'b0;
    random_quad(q);
    load_quad(q, 1'b0);
    for (int n = 0; n < 60; n++) begin
      pick_point(px, py);
      send_point(px, py);
    end
    drain_results();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_corners();
    test_square();
    test_full_span();
    test_random_quads();
    test_output_holdoff();
    test_streaming();
    if (expected_inside_q.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_inside_q.size()));
    $display("checked %0d points against %0d corner settings, %0d of them inside",
             checked_cnt, quad_cnt, inside_cnt);
    $display("edge, corner and degenerate cases, random idling, a %0d-cycle hold-off, %0d cycles",
             HOLD_CYCLES, cycle_cnt);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
